// File: rtl/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg: shared types for the swept box collision response unit
// Lane and sideband records handed from cell to cell along the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none
package sbc_pkg;
    localparam int QBITS    = 24;   // quotient bits, one per divider cell
    localparam int DIVW     = 25;   // |relative speed| fits 25 bits
    localparam int SPDW     = 25;   // relative speed, signed
    localparam int COORDW   = 24;
    localparam int TIMEW    = 24;

    localparam logic [TIMEW-1:0] TICK_RESET = 24'd65536;
    localparam logic [TIMEW-1:0] TIME_MAX   = 24'hFFFFFF;

    // one divider lane: remainder, divisor, partial quotient, saturation mark
    typedef struct packed {
        logic [DIVW-1:0]  rem;
        logic [DIVW-1:0]  dvs;
        logic [QBITS-1:0] quo;
        logic             sat;
    } sbc_lane_t;

    // item data that rides along the chain
    typedef struct packed {
        logic signed [COORDW-1:0] own_left;
        logic signed [COORDW-1:0] own_top;
        logic signed [SPDW-1:0]   dvx;
        logic signed [SPDW-1:0]   dvy;
        logic                     hit;
        logic                     move_x;
        logic                     move_y;
        logic [1:0]               flag_x;   // [0] right, [1] left
        logic [1:0]               flag_y;   // [0] floor, [1] ceiling
    } sbc_side_t;
endpackage
`default_nettype wire

// File: rtl/swept_box_collision_response_unit.sv
// From request acceptance to result valid an item passes 28 register stages:
// 1 entry stage, 24 divider cells, 1 axis select stage, 1 multiply stage, 1 output.
// Throughput: one request per cycle unless stalled; the divider chain sets the depth.
// A stalled output holds the whole pipeline in place.
// Reset: rst_n clears all valid bits, loads tick_length with 65536 (2^-8, Q0.24).
// ----------------------------------------------------------------------------
// swept_box_collision_response_unit: push one box out of another
// Overlap, time-to-separate via a chain of division cells, axis choice,
// clamp, push-back and contact flags.
// ----------------------------------------------------------------------------
`default_nettype none
module swept_box_collision_response_unit (
    input  wire         clk,
    input  wire         rst_n,
    // APB-style register port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request channel
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  signed [23:0] own_left,
    input  wire  signed [23:0] own_top,
    input  wire  [22:0] own_width,
    input  wire  [22:0] own_height,
    input  wire  signed [23:0] own_speed_x,
    input  wire  signed [23:0] own_speed_y,
    input  wire  signed [23:0] other_left,
    input  wire  signed [23:0] other_top,
    input  wire  [22:0] other_width,
    input  wire  [22:0] other_height,
    input  wire  signed [23:0] other_speed_x,
    input  wire  signed [23:0] other_speed_y,
    // result channel
    output logic        out_valid,
    input  wire         out_ready,
    output logic signed [23:0] new_left,
    output logic signed [23:0] new_top,
    output logic        overlapped,
    output logic [3:0]  contact_flags
);
    import sbc_pkg::*;

    localparam logic REG_TICK = 1'b0;

    // ---------------- register port ----------------
    logic [TIMEW-1:0] tick_reg;

    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_reg <= TICK_RESET;
        else if (psel && penable && pwrite && paddr[2] == REG_TICK)
            tick_reg <= pwdata[TIMEW-1:0];
    end
    assign prdata = (paddr[2] == REG_TICK) ? {8'd0, tick_reg} : 32'd0;

    // ---------------- global advance ----------------
    // Every stage moves when the output register is free or being drained.
    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // ---------------- entry stage: overlap and relative speed ----------------
    logic signed [24:0] ol_x, or_x, xr_x, ot_y, ob_y, xb_y, il, ir, it, ib;
    logic signed [25:0] iw, ih;
    logic signed [SPDW-1:0] dvx, dvy;
    logic [DIVW-1:0] adx, ady;
    logic hit;
    sbc_side_t side0;
    sbc_lane_t lx0, ly0;

    always_comb
    begin
        ol_x = 25'(own_left);
        or_x = 25'(own_left) + $signed({2'b00, own_width});
        xr_x = 25'(other_left) + $signed({2'b00, other_width});
        ot_y = 25'(own_top);
        ob_y = 25'(own_top) + $signed({2'b00, own_height});
        xb_y = 25'(other_top) + $signed({2'b00, other_height});
        il   = (ol_x > 25'(other_left)) ? ol_x : 25'(other_left);
        ir   = (or_x < xr_x) ? or_x : xr_x;
        it   = (ot_y > 25'(other_top)) ? ot_y : 25'(other_top);
        ib   = (ob_y < xb_y) ? ob_y : xb_y;
        iw   = 26'(ir) - 26'(il);
        ih   = 26'(ib) - 26'(it);
        hit  = (iw > 26'sd0) && (ih > 26'sd0);
        dvx  = 25'(own_speed_x) - 25'(other_speed_x);
        dvy  = 25'(own_speed_y) - 25'(other_speed_y);
        adx  = dvx[SPDW-1] ? DIVW'(-dvx) : DIVW'(dvx);
        ady  = dvy[SPDW-1] ? DIVW'(-dvy) : DIVW'(dvy);

        side0.own_left = own_left;
        side0.own_top  = own_top;
        side0.dvx      = dvx;
        side0.dvy      = dvy;
        side0.hit      = hit;
        side0.move_x   = (dvx != '0);
        side0.move_y   = (dvy != '0);
        side0.flag_x   = {(il != 25'(other_left)) && (ir == xr_x),
                          (il == 25'(other_left))};
        side0.flag_y   = {(it != 25'(other_top)) && (ib == xb_y),
                          (it == 25'(other_top))};

        // dividend starts below the divisor unless the quotient saturates
        lx0.rem = hit ? iw[DIVW-1:0] : '0;
        lx0.dvs = adx;
        lx0.quo = '0;
        lx0.sat = hit && (iw[DIVW-1:0] >= adx);
        ly0.rem = hit ? ih[DIVW-1:0] : '0;
        ly0.dvs = ady;
        ly0.quo = '0;
        ly0.sat = hit && (ih[DIVW-1:0] >= ady);
    end

    logic      v0_reg;
    sbc_lane_t lx0_reg, ly0_reg;
    sbc_side_t s0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lx0_reg <= lx0;
            ly0_reg <= ly0;
            s0_reg  <= side0;
        end
    end

    // ---------------- divider chain: one quotient bit per cell ----------------
    logic      cv [0:QBITS];
    sbc_lane_t cx [0:QBITS];
    sbc_lane_t cy [0:QBITS];
    sbc_side_t cs [0:QBITS];

    assign cv[0] = v0_reg;
    assign cx[0] = lx0_reg;
    assign cy[0] = ly0_reg;
    assign cs[0] = s0_reg;

    for (genvar g = 0; g < QBITS; g++)
    begin : g_cell
        sbc_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vld_in   (cv[g]),
            .lx_in    (cx[g]),
            .ly_in    (cy[g]),
            .side_in  (cs[g]),
            .vld_out  (cv[g+1]),
            .lx_out   (cx[g+1]),
            .ly_out   (cy[g+1]),
            .side_out (cs[g+1])
        );
    end

    // ---------------- axis select and clamp ----------------
    sbc_side_t  se;
    logic [TIMEW-1:0] tx, ty, dt, dt_cl;
    logic [3:0] fl;

    always_comb
    begin
        se = cs[QBITS];
        tx = cx[QBITS].sat ? TIME_MAX : cx[QBITS].quo;
        ty = cy[QBITS].sat ? TIME_MAX : cy[QBITS].quo;
        dt = '0;
        fl = 4'd0;
        if (se.hit)
        begin
            if (se.move_x && (!se.move_y || tx <= ty))
            begin
                dt = tx;
                fl = {se.flag_x, 2'b00};
            end
            else if (se.move_y)
            begin
                dt = ty;
                fl = {2'b00, se.flag_y};
            end
        end
        dt_cl = (dt > tick_reg) ? tick_reg : dt;
    end

    logic       v1_reg;
    logic [TIMEW-1:0] dt_reg;
    logic [3:0] fl1_reg;
    sbc_side_t  s1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= cv[QBITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dt_reg  <= dt_cl;
            fl1_reg <= fl;
            s1_reg  <= se;
        end
    end

    // ---------------- push-back products ----------------
    logic signed [49:0] px_next, py_next, px_reg, py_reg;
    logic       v2_reg;
    logic [3:0] fl2_reg;
    sbc_side_t  s2_reg;

    assign px_next = 50'($signed({1'b0, dt_reg})) * 50'(s1_reg.dvx);
    assign py_next = 50'($signed({1'b0, dt_reg})) * 50'(s1_reg.dvy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg  <= px_next;
            py_reg  <= py_next;
            fl2_reg <= fl1_reg;
            s2_reg  <= s1_reg;
        end
    end

    // ---------------- floor shift, subtract, saturate ----------------
    function automatic logic [COORDW-1:0] push(input logic signed [COORDW-1:0] c,
                                               input logic signed [49:0] p);
        logic signed [25:0] d;
        logic signed [26:0] n;
        d = 26'(p >>> 24);
        n = 27'(c) - 27'(d);
        if (n < -27'sd8388608)
            return 24'h800000;
        else if (n > 27'sd8388607)
            return 24'h7FFFFF;
        else
            return n[COORDW-1:0];
    endfunction

    logic        vo_reg;
    logic [23:0] nl_reg, nt_reg;
    logic        hit_reg;
    logic [3:0]  fo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nl_reg  <= push(s2_reg.own_left, px_reg);
            nt_reg  <= push(s2_reg.own_top, py_reg);
            hit_reg <= s2_reg.hit;
            fo_reg  <= fl2_reg;
        end
    end

    assign out_valid     = vo_reg;
    assign new_left      = nl_reg;
    assign new_top       = nt_reg;
    assign overlapped    = hit_reg;
    assign contact_flags = fo_reg;
endmodule
`default_nettype wire

// File: rtl/sbc_div_cell.sv
// ----------------------------------------------------------------------------
// sbc_div_cell: one restoring division step for both axes
// Resolves one quotient bit per lane and hands the item to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module sbc_div_cell (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 en,
    input  wire                 vld_in,
    input  sbc_pkg::sbc_lane_t  lx_in,
    input  sbc_pkg::sbc_lane_t  ly_in,
    input  sbc_pkg::sbc_side_t  side_in,
    output logic                vld_out,
    output sbc_pkg::sbc_lane_t  lx_out,
    output sbc_pkg::sbc_lane_t  ly_out,
    output sbc_pkg::sbc_side_t  side_out
);
    import sbc_pkg::*;

    logic      vld_reg;
    sbc_lane_t lx_reg, lx_next, ly_reg, ly_next;
    sbc_side_t side_reg;

    function automatic sbc_lane_t step(input sbc_lane_t l);
        sbc_lane_t  o;
        logic [DIVW:0] r2;
        o  = l;
        r2 = {l.rem, 1'b0};
        if (r2 >= {1'b0, l.dvs})
        begin
            o.rem = DIVW'(r2 - {1'b0, l.dvs});
            o.quo = {l.quo[QBITS-2:0], 1'b1};
        end
        else
        begin
            o.rem = r2[DIVW-1:0];
            o.quo = {l.quo[QBITS-2:0], 1'b0};
        end
        return o;
    endfunction

    assign lx_next = step(lx_in);
    assign ly_next = step(ly_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lx_reg   <= lx_next;
            ly_reg   <= ly_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign lx_out   = lx_reg;
    assign ly_out   = ly_reg;
    assign side_out = side_reg;
endmodule
`default_nettype wire

// File: rtl/sbc_checker.sv
// ----------------------------------------------------------------------------
// sbc_checker: port-level checks for the collision response unit
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module sbc_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire [23:0] new_left,
    input wire        overlapped,
    input wire [3:0]  contact_flags
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_left))
        else $error("result dropped or changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request refused with empty output");

    a_flags_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0(contact_flags))
        else $error("more than one contact flag");

    a_flags_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !overlapped |-> contact_flags == 4'd0)
        else $error("contact without overlap");
endmodule

bind swept_box_collision_response_unit sbc_checker u_sbc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .new_left      (new_left),
    .overlapped    (overlapped),
    .contact_flags (contact_flags)
);
`default_nettype wire

// File: bench/sbc_response_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbc_response_checker: response predictor and scoreboard
// Watches the request and result channels and the register port, predicts
// each corrected position and its contact flags, and counts mismatches.
// ----------------------------------------------------------------------------
module sbc_response_checker (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [2:0]         paddr,
    input  wire  [31:0]        pwdata,
    input  wire                in_valid,
    input  wire                in_ready,
    input  wire  signed [23:0] own_left,
    input  wire  signed [23:0] own_top,
    input  wire  [22:0]        own_width,
    input  wire  [22:0]        own_height,
    input  wire  signed [23:0] own_speed_x,
    input  wire  signed [23:0] own_speed_y,
    input  wire  signed [23:0] other_left,
    input  wire  signed [23:0] other_top,
    input  wire  [22:0]        other_width,
    input  wire  [22:0]        other_height,
    input  wire  signed [23:0] other_speed_x,
    input  wire  signed [23:0] other_speed_y,
    input  wire                out_valid,
    input  wire                out_ready,
    input  wire  signed [23:0] new_left,
    input  wire  signed [23:0] new_top,
    input  wire                overlapped,
    input  wire  [3:0]         contact_flags,
    output int                 error_count,
    output int                 pending_count
);
    localparam logic [2:0] ADDR_TICK_LENGTH = 3'd0;
    localparam longint COORD_LO = -64'sd8388608;
    localparam longint COORD_HI = 64'sd8388607;

    typedef enum int { AXIS_NONE, AXIS_VERT, AXIS_HORZ } axis_e;

    typedef struct packed {
        logic [23:0] left;
        logic [23:0] top;
        logic        hit;
        logic [3:0]  flags;
    } response_t;

    response_t   expected_q[$];
    logic [23:0] tick_length;

    function automatic longint time_to_clear(longint ovl, longint spd);
        longint mag;
        longint q;
        mag = (spd < 0) ? -spd : spd;
        q = (ovl <<< 24) / mag;
        return (q > 64'sd16777215) ? 64'sd16777215 : q;
    endfunction

    function automatic longint push_back(longint t, longint v);
        longint p;
        p = t * v;
        if (p >= 0)
            return p >>> 24;
        return -((-p + 64'sd16777215) >>> 24);
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v < COORD_LO) return COORD_LO;
        if (v > COORD_HI) return COORD_HI;
        return v;
    endfunction

    function automatic response_t resolve_collision();
        response_t r;
        longint ol, ot, xl, xt, il, ir, it, ib, dvx, dvy, dt, tx, ty, nl, nt;
        longint ow, oh, xw, xh;
        axis_e axis;
        ol = own_left;  ot = own_top;  xl = other_left;  xt = other_top;
        ow = longint'(own_width);    oh = longint'(own_height);
        xw = longint'(other_width);  xh = longint'(other_height);
        il = (ol > xl) ? ol : xl;
        ir = (ol + ow < xl + xw) ? ol + ow : xl + xw;
        it = (ot > xt) ? ot : xt;
        ib = (ot + oh < xt + xh) ? ot + oh : xt + xh;
        nl = ol;  nt = ot;
        r = '0;
        if (ir - il > 0 && ib - it > 0) begin
            r.hit = 1'b1;
            dvx = longint'(own_speed_x) - longint'(other_speed_x);
            dvy = longint'(own_speed_y) - longint'(other_speed_y);
            dt = 0;
            axis = AXIS_NONE;
            if (dvx != 0 && dvy != 0) begin
                tx = time_to_clear(ir - il, dvx);
                ty = time_to_clear(ib - it, dvy);
                if (tx > ty) begin dt = ty; axis = AXIS_VERT; end
                else begin dt = tx; axis = AXIS_HORZ; end
            end else if (dvx != 0) begin
                dt = time_to_clear(ir - il, dvx);  axis = AXIS_HORZ;
            end else if (dvy != 0) begin
                dt = time_to_clear(ib - it, dvy);  axis = AXIS_VERT;
            end
            if (dt > longint'(tick_length)) dt = tick_length;
            nl = clamp_coord(ol - push_back(dt, dvx));
            nt = clamp_coord(ot - push_back(dt, dvy));
            if (axis == AXIS_VERT) begin
                if (it == xt) r.flags[0] = 1'b1;
                else if (ib == xt + xh) r.flags[1] = 1'b1;
            end else if (axis == AXIS_HORZ) begin
                if (il == xl) r.flags[2] = 1'b1;
                else if (ir == xl + xw) r.flags[3] = 1'b1;
            end
        end
        r.left = nl[23:0];
        r.top  = nt[23:0];
        return r;
    endfunction

    assign pending_count = expected_q.size();

    always @(posedge clk or negedge rst_n) begin
        response_t want;
        if (!rst_n) begin
            tick_length <= 24'd65536;
            error_count <= 0;
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && paddr == ADDR_TICK_LENGTH)
                tick_length <= pwdata[23:0];
            if (in_valid && in_ready)
                expected_q.push_back(resolve_collision());
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result with no request pending");
                    error_count <= error_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (new_left !== want.left || new_top !== want.top ||
                        overlapped !== want.hit || contact_flags !== want.flags) begin
                        if (new_left !== want.left)
                            $error("new_left exp %0d got %0d",
                                   $signed(want.left), new_left);
                        if (new_top !== want.top)
                            $error("new_top exp %0d got %0d",
                                   $signed(want.top), new_top);
                        if (overlapped !== want.hit)
                            $error("overlapped exp %0b got %0b", want.hit, overlapped);
                        if (contact_flags !== want.flags)
                            $error("contact_flags exp %h got %h",
                                   want.flags, contact_flags);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end
endmodule

// File: bench/tb_swept_box_collision_response_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_swept_box_collision_response_unit: collision response unit testbench
// Streams directed and random box pairs through the unit under several tick
// lengths, with random gaps on both channels; the checker scores each result.
// ----------------------------------------------------------------------------
module tb_swept_box_collision_response_unit;
    localparam logic [2:0] ADDR_TICK_LENGTH = 3'd0;
    localparam int LATENCY     = 28;
    localparam int CYCLE_LIMIT = 400000;

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [23:0] own_left, own_top, own_speed_x, own_speed_y;
    logic signed [23:0] other_left, other_top, other_speed_x, other_speed_y;
    logic [22:0] own_width, own_height, other_width, other_height;
    logic signed [23:0] new_left, new_top;
    logic overlapped;
    logic [3:0] contact_flags;
    int error_count, pending_count;
    int cycle_count;

    swept_box_collision_response_unit u_dut (.*);
    sbc_response_checker u_checker (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up on a hung pipeline.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one, often none.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Stall the result side at random.
    initial begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            out_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) begin
                stall = pick_gap();
                repeat (stall) begin
                    @(negedge clk);
                    out_ready <= 1'b0;
                end
            end
        end
    end

    task automatic write_tick(input logic [23:0] value);
        @(negedge clk);
        psel <= 1'b1;  pwrite <= 1'b1;  paddr <= ADDR_TICK_LENGTH;
        pwdata <= {8'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;  penable <= 1'b0;  pwrite <= 1'b0;
    endtask

    // Hold the request until accepted at a rising edge.
    task automatic send_request(input logic signed [23:0] ol, ot,
                                input logic [22:0] ow, oh,
                                input logic signed [23:0] osx, osy, xl, xt,
                                input logic [22:0] xw, xh,
                                input logic signed [23:0] xsx, xsy);
        in_valid <= 1'b1;
        own_left <= ol;  own_top <= ot;  own_width <= ow;  own_height <= oh;
        own_speed_x <= osx;  own_speed_y <= osy;
        other_left <= xl;  other_top <= xt;  other_width <= xw;  other_height <= xh;
        other_speed_x <= xsx;  other_speed_y <= xsy;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (pick_gap() != 0) begin
            in_valid <= 1'b0;
            repeat (pick_gap()) @(negedge clk);
        end
    endtask

    // Random pair: other box placed around the own box, overlapping or not.
    task automatic send_overlap_pair();
        logic signed [23:0] ol, ot;
        logic [22:0] ow, oh;
        ow = $urandom_range(1, 4096);  oh = $urandom_range(1, 4096);
        ol = $urandom_range(0, 65535) - 32768;
        ot = $urandom_range(0, 65535) - 32768;
        send_request(ol, ot, ow, oh,
                     ($urandom_range(0, 3) == 0) ? 24'sd0 : 24'($urandom),
                     ($urandom_range(0, 3) == 0) ? 24'sd0 : 24'($urandom),
                     ol + $signed(24'($urandom_range(0, 2 * ow))) - ow,
                     ot + $signed(24'($urandom_range(0, 2 * oh))) - oh,
                     $urandom_range(1, 4096), $urandom_range(1, 4096),
                     ($urandom_range(0, 3) == 0) ? 24'sd0 : 24'($urandom),
                     ($urandom_range(0, 3) == 0) ? 24'sd0 : 24'($urandom));
    endtask

    task automatic send_noise_pair();
        send_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Drain the pipeline before touching the register; called at a falling edge.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    initial begin
        logic [23:0] ticks[5];
        rst_n = 1'b0;  cycle_count = 0;
        psel = 1'b0;  penable = 1'b0;  pwrite = 1'b0;  paddr = '0;  pwdata = '0;
        in_valid = 1'b0;
        own_left = '0;  own_top = '0;  own_width = '0;  own_height = '0;
        own_speed_x = '0;  own_speed_y = '0;
        other_left = '0;  other_top = '0;  other_width = '0;  other_height = '0;
        other_speed_x = '0;  other_speed_y = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: disjoint, touching edges, still pair, single axis,
        // horizontal tie, flag cases, saturation at the coordinate extremes.
        send_request(0, 0, 256, 256, 0, 0, 1000, 1000, 256, 256, 0, 0);
        send_request(0, 0, 256, 256, 65536, 0, 256, 0, 256, 256, 0, 0);
        send_request(0, 0, 256, 256, 0, 0, 128, 128, 256, 256, 0, 0);
        send_request(0, 0, 256, 256, 65536, 0, 128, 64, 256, 256, 0, 0);
        send_request(0, 0, 256, 256, 0, 65536, 64, 128, 256, 256, 0, 0);
        send_request(0, 0, 256, 256, 65536, 65536, 128, 128, 256, 256, 0, 0);
        send_request(0, 0, 256, 256, -65536, -65536, -128, -128, 256, 256, 0, 0);
        send_request(0, 0, 256, 256, 65536, 32768, 100, 0, 256, 256, 0, 0);
        send_request(0, 0, 256, 256, 65536, 32768, 0, 100, 256, 256, 0, 0);
        send_request(0, 0, 512, 512, 65536, 65536, 0, 0, 256, 256, 0, 0);
        send_request(0, 0, 512, 512, 65536, 65536, 256, 256, 256, 256, 0, 0);
        send_request(24'sh800000, 24'sh800000, 23'h7FFFFF, 23'h7FFFFF,
                     24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000,
                     23'h7FFFFF, 23'h7FFFFF, 24'sh800000, 24'sh800000);
        send_request(24'sh7FFFFF, 24'sh7FFFFF, 23'h7FFFFF, 23'h7FFFFF,
                     24'sh800000, 24'sh800000, 24'sh7FFFF0, 24'sh7FFFF0,
                     23'h7FFFFF, 23'h7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        send_request(24'sh800000, 0, 23'h7FFFFF, 256, 1, 1, 24'sh800000, 0,
                     23'h7FFFFF, 256, 0, 0);
        send_request(0, 0, 23'h7FFFFF, 23'h7FFFFF, 24'sh7FFFFF, 24'sh800000,
                     10, 10, 23'h7FFFFF, 23'h7FFFFF, 24'sh800000, 24'sh7FFFFF);
        send_request(0, 0, 0, 0, 65536, 65536, 0, 0, 256, 256, 0, 0);

        // Random phases over several tick lengths, extremes included.
        ticks = '{24'd0, 24'hFFFFFF, 24'd1, 24'd32768, 24'd65536};
        foreach (ticks[i]) begin
            wait_idle();
            write_tick(ticks[i]);
            repeat (140) begin
                if ($urandom_range(0, 9) < 8) send_overlap_pair();
                else send_noise_pair();
            end
        end

        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
